### hdl/uup_pkg.sv
// shared types and constants for the uuid text parser
package uup_pkg;

  localparam int unsigned UUID_BYTES = 16;
  localparam int unsigned CNT_W      = $clog2(UUID_BYTES + 1);
  localparam int unsigned IDX_W      = $clog2(UUID_BYTES);
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_OPEN   = 8'h7b;
  localparam logic [7:0] CH_CLOSE  = 8'h7d;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;

  typedef enum logic [2:0] {
    CLS_HEX,
    CLS_HYPHEN,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BRACE   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] nib;
    logic       last;
    logic       none;
  } token_t;

endpackage

### hdl/uuid_text_parser.sv
// top level of the uuid text parser
// Takes one character beat per cycle while s_axis_tready is high and returns
// one result beat on the beat marked tlast. Characters are classified on entry
// and held in a four-beat queue; the parse state and result register behind it
// consume one beat per cycle, but a tlast beat waits till the prior result is
// taken, so the sustained rate is one character per clock while results drain.
// The final character is written into the queue; the result register loads as
// it is popped. Input stalls only when the queue is full, which happens only
// while a finished result waits to be taken.
module uuid_text_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // char_code
  input  logic          s_axis_tlast,   // is_last
  input  logic          s_axis_tuser,   // no_char
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // uuid_low, uuid_high
  output logic [1:0]    m_axis_tuser    // status
);
  import uup_pkg::*;

  token_t  in_tok, q_tok;
  logic    q_full, q_valid, q_pop;
  status_e res_status;
  logic [63:0] res_high, res_low;

  uup_front u_front (
    .char_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .none_i (s_axis_tuser),
    .tok_o  (in_tok)
  );

  uup_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_tok_i (in_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_tok_o  (q_tok)
  );

  uup_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (q_valid),
    .tok_i        (q_tok),
    .pop_o        (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_high_o   (res_high),
    .res_low_o    (res_low)
  );

  assign s_axis_tready = !q_full;
  assign m_axis_tdata  = {res_low, res_high};
  assign m_axis_tuser  = res_status;

endmodule

### hdl/uup_front.sv
// front end: classifies each incoming character into a token
module uup_front (
  input  logic [7:0]      char_i,
  input  logic            last_i,
  input  logic            none_i,
  output uup_pkg::token_t tok_o
);
  import uup_pkg::*;

  always_comb begin
    tok_o.last = last_i;
    tok_o.none = none_i;
    tok_o.nib  = 4'd0;
    tok_o.cls  = CLS_OTHER;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      tok_o.cls = CLS_HEX;
      tok_o.nib = 4'(char_i - 8'h30);
    end else if (char_i >= 8'h61 && char_i <= 8'h66) begin
      tok_o.cls = CLS_HEX;
      tok_o.nib = 4'(char_i - 8'h57);
    end else if (char_i >= 8'h41 && char_i <= 8'h46) begin
      tok_o.cls = CLS_HEX;
      tok_o.nib = 4'(char_i - 8'h37);
    end else if (char_i == CH_HYPHEN) begin
      tok_o.cls = CLS_HYPHEN;
    end else if (char_i == CH_OPEN) begin
      tok_o.cls = CLS_OPEN;
    end else if (char_i == CH_CLOSE) begin
      tok_o.cls = CLS_CLOSE;
    end
  end

endmodule

### hdl/uup_queue.sv
// short token queue between front end and back end
module uup_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  uup_pkg::token_t push_tok_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output uup_pkg::token_t pop_tok_o
);
  import uup_pkg::*;

  token_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o    = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_tok_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

### hdl/uup_back.sv
// back end: parse state, byte store and result register
module uup_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tok_valid_i,
  input  uup_pkg::token_t      tok_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output uup_pkg::status_e     res_status_o,
  output logic [63:0]          res_high_o,
  output logic [63:0]          res_low_o
);
  import uup_pkg::*;

  logic [7:0]       store_q [UUID_BYTES];
  logic [CNT_W-1:0] count_q, count_d;
  logic             half_q, half_d;
  logic [3:0]       held_q, held_d;
  logic             brace_q, brace_d;
  logic             start_q, start_d;
  logic             inval_q, inval_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [63:0]      out_high_q, out_low_q;

  logic             out_free, opener, close_ok, take, wr, brace_eff;
  logic [7:0]       new_byte;
  logic [IDX_W-1:0] wr_idx;
  status_e          status;
  logic [63:0]      high_v, low_v;

  assign out_free = !out_valid_q || res_ready_i;
  assign pop_o    = tok_valid_i && (!tok_i.last || out_free);
  assign wr_idx   = count_q[IDX_W-1:0];
  assign new_byte = {held_q, tok_i.nib};

  always_comb begin
    count_d  = count_q;
    half_d   = half_q;
    held_d   = held_q;
    brace_d  = brace_q;
    start_d  = start_q;
    inval_d  = inval_q;
    wr       = 1'b0;
    opener   = !tok_i.none && start_q && (tok_i.cls == CLS_OPEN);
    close_ok = !tok_i.none && !opener && tok_i.last && brace_q && (tok_i.cls == CLS_CLOSE);
    take     = !tok_i.none && !opener && !(tok_i.last && brace_q);
    if (!tok_i.none) begin
      start_d = 1'b0;
    end
    if (opener) begin
      brace_d = 1'b1;
    end
    if (take && tok_i.cls != CLS_HYPHEN) begin
      if (tok_i.cls != CLS_HEX || count_q >= CNT_W'(UUID_BYTES)) begin
        inval_d = 1'b1;
      end else if (!inval_q) begin
        if (!half_q) begin
          held_d = tok_i.nib;
          half_d = 1'b1;
        end else begin
          wr      = 1'b1;
          count_d = count_q + 1'b1;
          half_d  = 1'b0;
        end
      end
    end
  end

  always_comb begin
    brace_eff = brace_q || opener;
    if (tok_i.none && start_q) begin
      status = ST_EMPTY;
    end else if (brace_eff && !close_ok) begin
      status = ST_BRACE;
    end else if (inval_d || count_d != CNT_W'(UUID_BYTES) || half_d) begin
      status = ST_INVALID;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    high_v = '0;
    low_v  = '0;
    if (status == ST_OK) begin
      for (int k = 0; k < UUID_BYTES / 2; k++) begin
        high_v[63-8*k -: 8] = (wr && wr_idx == IDX_W'(k)) ? new_byte : store_q[k];
        low_v[63-8*k -: 8]  = (wr && wr_idx == IDX_W'(k + UUID_BYTES / 2)) ?
                              new_byte : store_q[k + UUID_BYTES / 2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      half_q      <= 1'b0;
      held_q      <= '0;
      brace_q     <= 1'b0;
      start_q     <= 1'b1;
      inval_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (tok_i.last) begin
          count_q <= '0;
          half_q  <= 1'b0;
          held_q  <= '0;
          brace_q <= 1'b0;
          start_q <= 1'b1;
          inval_q <= 1'b0;
        end else begin
          count_q <= count_d;
          half_q  <= half_d;
          held_q  <= held_d;
          brace_q <= brace_d;
          start_q <= start_d;
          inval_q <= inval_d;
        end
      end
      if (pop_o && tok_i.last) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && wr) begin
      store_q[wr_idx] <= new_byte;
    end
    if (pop_o && tok_i.last) begin
      out_status_q <= status;
      out_high_q   <= high_v;
      out_low_q    <= low_v;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_high_o   = out_high_q;
  assign res_low_o    = out_low_q;

endmodule

### tb/sv/uuid_text_parser_tb.sv
// self-checking testbench for the uuid text parser: directed character table, then random uuid strings
module uuid_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uup_pkg::*;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam int unsigned TEXT_ITEMS = 900;
  localparam int unsigned CALM_ITEMS = 780;

  typedef struct {
    status_e     st;
    logic [63:0] hi;
    logic [63:0] lo;
  } uuid_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       none;
    logic       fixed;
    status_e    st;
  } dir_row_t;

  localparam int unsigned DIR_N = 20;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'h00,      1'b1, 1'b1, 1'b1, ST_EMPTY},
    '{8'hff,      1'b0, 1'b1, 1'b0, ST_OK},
    '{CH_OPEN,    1'b1, 1'b0, 1'b1, ST_BRACE},
    '{CH_OPEN,    1'b0, 1'b0, 1'b0, ST_OK},
    '{CH_CLOSE,   1'b1, 1'b0, 1'b0, ST_OK},
    '{CH_OPEN,    1'b0, 1'b0, 1'b0, ST_OK},
    '{CH_LOWER_A, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00,      1'b1, 1'b0, 1'b1, ST_BRACE},
    '{CH_OPEN,    1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h35,      1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00,      1'b1, 1'b1, 1'b1, ST_BRACE},
    '{CH_HYPHEN,  1'b1, 1'b0, 1'b1, ST_INVALID},
    '{8'hff,      1'b0, 1'b0, 1'b0, ST_OK},
    '{CH_CLOSE,   1'b1, 1'b0, 1'b1, ST_INVALID},
    '{CH_UPPER_A, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h66,      1'b0, 1'b0, 1'b0, ST_OK},
    '{CH_OPEN,    1'b1, 1'b0, 1'b1, ST_INVALID},
    '{8'h39,      1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hff,      1'b1, 1'b1, 1'b1, ST_INVALID},
    '{8'hff,      1'b1, 1'b1, 1'b1, ST_EMPTY}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // char_code
  logic         s_axis_tlast = 1'b0;    // is_last
  logic         s_axis_tuser = 1'b0;    // no_char
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;           // uuid_low, uuid_high
  logic [1:0]   m_axis_tuser;           // status

  logic    item_fixed = 1'b0;
  status_e item_status = ST_OK;
  bit      calm = 1'b0;
  int      hold_cnt = 0;
  int      fails = 0;
  int      items_sent = 0;

  uuid_result_t pending_uuids [$];

  logic [7:0] text_bytes [UUID_BYTES];
  logic [4:0] text_count;
  bit         nib_held;
  logic [3:0] nib_val;
  bit         braced;
  bit         fresh;
  bit         bad;

  uuid_text_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_text();
    foreach (text_bytes[k]) text_bytes[k] = 8'h00;
    text_count = '0;
    nib_held   = 1'b0;
    nib_val    = '0;
    braced     = 1'b0;
    fresh      = 1'b1;
    bad        = 1'b0;
  endfunction

  function automatic bit hex_value(input logic [7:0] ch, output logic [3:0] v);
    v = '0;
    if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd9) v = 4'(ch - CH_ZERO);
    else if (ch >= CH_LOWER_A && ch <= CH_LOWER_A + 8'd5) v = 4'(ch - CH_LOWER_A + 8'd10);
    else if (ch >= CH_UPPER_A && ch <= CH_UPPER_A + 8'd5) v = 4'(ch - CH_UPPER_A + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void absorb_char(input logic [7:0] ch);
    logic [3:0] v;
    if (ch == CH_HYPHEN) return;
    if (!hex_value(ch, v) || text_count >= UUID_BYTES) begin
      bad = 1'b1;
      return;
    end
    if (bad) return;
    if (!nib_held) begin
      nib_val  = v;
      nib_held = 1'b1;
    end else begin
      text_bytes[text_count[3:0]] = {nib_val, v};
      text_count = text_count + 5'd1;
      nib_held   = 1'b0;
    end
  endfunction

  function automatic bit parse_char(input logic [7:0] ch, input logic last, input logic none,
                                    output uuid_result_t r);
    bit was_fresh;
    bit opener;
    bit closed;
    was_fresh = fresh;
    closed    = 1'b0;
    r = '{st: ST_OK, hi: '0, lo: '0};
    if (none && !last) return 1'b0;
    if (!none) begin
      opener = was_fresh && ch == CH_OPEN;
      fresh  = 1'b0;
      if (opener) begin
        braced = 1'b1;
        if (!last) return 1'b0;
      end else if (last && braced) begin
        closed = (ch == CH_CLOSE);
      end else begin
        absorb_char(ch);
      end
      if (!last) return 1'b0;
    end
    if (none && was_fresh) r.st = ST_EMPTY;
    else if (braced && !closed) r.st = ST_BRACE;
    else if (bad || text_count != UUID_BYTES || nib_held) r.st = ST_INVALID;
    else r.st = ST_OK;
    if (r.st == ST_OK) begin
      for (int k = 0; k < 8; k++) begin
        r.hi = {r.hi[55:0], text_bytes[k]};
        r.lo = {r.lo[55:0], text_bytes[k + 8]};
      end
    end
    clear_text();
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : check_beats
    uuid_result_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_char(s_axis_tdata, s_axis_tlast, s_axis_tuser, r)) begin
          if (item_fixed) r = '{st: item_status, hi: '0, lo: '0};
          pending_uuids.push_back(r);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_uuids.size() == 0) begin
          $error("unexpected result beat: status %0d", m_axis_tuser);
          fails++;
        end else begin
          r = pending_uuids.pop_front();
          if (m_axis_tuser !== r.st) begin
            $error("status: expected %0d, got %0d", r.st, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[63:0] !== r.hi) begin
            $error("uuid_high: expected %h, got %h", r.hi, m_axis_tdata[63:0]);
            fails++;
          end
          if (m_axis_tdata[127:64] !== r.lo) begin
            $error("uuid_low: expected %h, got %h", r.lo, m_axis_tdata[127:64]);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      hold_cnt      <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic last, input logic none,
                           input logic fixed, input status_e st);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    s_axis_tuser  <= none;
    item_fixed    <= fixed;
    item_status   <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!(none && !last)) items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_uuids.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    if ($urandom_range(0, 1) == 0) return CH_UPPER_A + 8'(v) - 8'd10;
    return CH_LOWER_A + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 4))
      0: return CH_OPEN;
      1: return CH_CLOSE;
      2: return CH_HYPHEN;
      3: return hex_char(4'($urandom));
      default: return 8'($urandom);
    endcase
  endfunction

  // kinds 0..5 well formed, 6 corrupted char, 7 random digit count, 8 no closer if braced, 9 noise
  task automatic send_random_text();
    logic [7:0] txt [$];
    int kind;
    int ndig;
    int fill_mode;
    bit use_brace;
    bit std_dash;
    bit end_none;
    logic [3:0] v;
    kind      = $urandom_range(0, 9);
    use_brace = $urandom_range(0, 1);
    end_none  = ($urandom_range(0, 9) == 0);
    if (kind == 9) begin
      repeat ($urandom_range(0, 6)) txt.push_back(noise_char());
    end else begin
      ndig = 32;
      if (kind == 7) begin
        case ($urandom_range(0, 3))
          0: ndig = 31;
          1: ndig = 33;
          2: ndig = 34;
          default: ndig = $urandom_range(0, 40);
        endcase
      end
      std_dash  = ($urandom_range(0, 3) != 0);
      fill_mode = $urandom_range(0, 7);
      if (use_brace) txt.push_back(CH_OPEN);
      for (int i = 0; i < ndig; i++) begin
        if (std_dash && (i == 8 || i == 12 || i == 16 || i == 20)) txt.push_back(CH_HYPHEN);
        else if (!std_dash && $urandom_range(0, 9) == 0) txt.push_back(CH_HYPHEN);
        v = (fill_mode == 0) ? 4'h0 : (fill_mode == 1) ? 4'hf : 4'($urandom);
        txt.push_back(hex_char(v));
      end
      if (use_brace && kind != 8) txt.push_back(CH_CLOSE);
      if (kind == 6 && txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = noise_char();
    end
    if (txt.size() == 0) end_none = 1'b1;
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(0, 24) == 0) send_item(8'($urandom), 1'b0, 1'b1, 1'b0, ST_OK);
      send_item(txt[i], !end_none && i == txt.size() - 1, 1'b0, 1'b0, ST_OK);
    end
    if (end_none) send_item(8'($urandom), 1'b1, 1'b1, 1'b0, ST_OK);
  endtask

  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    clear_text();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIR_N; i++) begin
      send_item(DIR_ROWS[i].ch, DIR_ROWS[i].last, DIR_ROWS[i].none,
                DIR_ROWS[i].fixed, DIR_ROWS[i].st);
    end
    drain_results();
    while (items_sent < TEXT_ITEMS) begin
      if (!drained_mid && items_sent >= TEXT_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
      if (items_sent >= CALM_ITEMS) calm = 1'b1;
      send_random_text();
    end
    drain_results();
    repeat (8) @(posedge clk_i);
    if (fails == 0 && pending_uuids.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
hdl/uup_pkg.sv
hdl/uup_front.sv
hdl/uup_queue.sv
hdl/uup_back.sv
hdl/uuid_text_parser.sv
tb/sv/uuid_text_parser_tb.sv
